/* rtl/core/lma_pkg.sv */
// ----------------------------------------------------------------------------
// Light level moving average package
// Shared defaults, the sequencer state type and the divider status record.
// ----------------------------------------------------------------------------
package lma_pkg;

    localparam int LMA_WINDOW          = 8;
    localparam int LMA_SAMPLE_BITS     = 10;
    localparam int LMA_THRESHOLD_RESET = 512;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TOTAL  = 4'b0010,
        S_DIV    = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/core/lma_ring.sv */
// ----------------------------------------------------------------------------
// Sample ring memory
// One write port and one registered read port over WINDOW stored samples.
// ----------------------------------------------------------------------------
module lma_ring
    import lma_pkg::*;
#(
    parameter int WINDOW      = LMA_WINDOW,
    parameter int SAMPLE_BITS = LMA_SAMPLE_BITS,
    parameter int POS_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [POS_W-1:0]       i_waddr,
    input  logic [SAMPLE_BITS-1:0] i_wdata,
    input  logic                   i_re,
    input  logic [POS_W-1:0]       i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lma_div.sv */
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; the remainder stays below the divisor.
// ----------------------------------------------------------------------------
module lma_div
    import lma_pkg::*;
#(
    parameter int TOT_W = 13,
    parameter int CNT_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TOT_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic [TOT_W-1:0] o_quotient,
    output t_div_stat        o_stat
);

    localparam int ITER_W = $clog2(TOT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [TOT_W-1:0]  r_quo;
    logic [CNT_W:0]    w_trial;
    logic              w_fits;

    assign w_trial = {r_rem, r_quo[TOT_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ITER_W'(TOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= CNT_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[CNT_W-1:0];
            end
            r_quo <= {r_quo[TOT_W-2:0], w_fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* rtl/core/light_level_moving_average.sv */
// ----------------------------------------------------------------------------
// Light level moving average
// A request passes through S_TOTAL, S_DIV and S_RESULT; in S_DIV the serial divider
// makes one quotient bit per cycle, and S_RESULT holds the result while the output stalls.
// Ready is low while a request is in work, so a new one is taken only in S_IDLE.
// Reset (synchronous, active low) clears the total, position, fill flag and
// extremes and restores the threshold; the sample ring keeps its contents.
// ----------------------------------------------------------------------------
module light_level_moving_average
    import lma_pkg::*;
#(
    parameter int WINDOW      = LMA_WINDOW,
    parameter int SAMPLE_BITS = LMA_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SAMPLE_BITS-1:0] i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_mean_level,
    output logic [SAMPLE_BITS-1:0] o_lowest_mean,
    output logic [SAMPLE_BITS-1:0] o_highest_mean,
    output logic                   o_is_dark,
    output logic                   o_is_light,
    output logic                   o_window_full
);

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOT_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [SAMPLE_BITS-1:0] THR_RST = SAMPLE_BITS'(LMA_THRESHOLD_RESET);

    t_state                 r_state;
    t_state                 n_state;
    logic [SAMPLE_BITS-1:0] r_threshold;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic                   r_filled;
    logic                   n_filled;
    logic [TOT_W-1:0]       r_total;
    logic [TOT_W-1:0]       n_total;
    logic [CNT_W-1:0]       n_count;
    logic [SAMPLE_BITS-1:0] r_lowest;
    logic [SAMPLE_BITS-1:0] r_highest;
    logic                   r_o_valid;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic [SAMPLE_BITS-1:0] r_o_lowest;
    logic [SAMPLE_BITS-1:0] r_o_highest;
    logic                   r_dark;
    logic                   r_light;
    logic                   r_full;
    logic [SAMPLE_BITS-1:0] w_old;
    logic [TOT_W-1:0]       w_quo;
    logic [SAMPLE_BITS-1:0] w_mean;
    logic [SAMPLE_BITS-1:0] w_low;
    logic [SAMPLE_BITS-1:0] w_high;
    t_div_stat              w_div;
    logic                   w_accept;
    logic                   w_out_free;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    lma_ring #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_TOTAL),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_re    (w_accept),
        .i_raddr (r_pos),
        .o_rdata (w_old)
    );

    always_comb begin
        n_pos    = (r_pos == POS_W'(WINDOW - 1)) ? '0 : POS_W'(r_pos + 1'b1);
        n_filled = r_filled || (n_pos == '0);
        n_count  = n_filled ? CNT_W'(WINDOW) : CNT_W'(n_pos);
        n_total  = r_total - (r_filled ? TOT_W'(w_old) : '0) + TOT_W'(r_sample);
    end

    lma_div #(
        .TOT_W (TOT_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_TOTAL),
        .i_dividend (n_total),
        .i_divisor  (n_count),
        .o_quotient (w_quo),
        .o_stat     (w_div)
    );

    assign w_mean = w_quo[SAMPLE_BITS-1:0];
    assign w_low  = (w_mean < r_lowest) ? w_mean : r_lowest;
    assign w_high = (w_mean > r_highest) ? w_mean : r_highest;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_TOTAL;
                end
            end
            S_TOTAL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= THR_RST;
            r_pos       <= '0;
            r_filled    <= 1'b0;
            r_total     <= '0;
            r_lowest    <= '1;
            r_highest   <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            if (r_state == S_TOTAL) begin
                r_pos    <= n_pos;
                r_filled <= n_filled;
                r_total  <= n_total;
            end
            if (r_state == S_RESULT && w_out_free) begin
                r_lowest  <= w_low;
                r_highest <= w_high;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
        end
        if (r_state == S_RESULT && w_out_free) begin
            r_mean      <= w_mean;
            r_o_lowest  <= w_low;
            r_o_highest <= w_high;
            r_dark      <= (w_mean < r_threshold);
            r_light     <= (w_mean > r_threshold);
            r_full      <= r_filled;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_mean_level   = r_mean;
    assign o_lowest_mean  = r_o_lowest;
    assign o_highest_mean = r_o_highest;
    assign o_is_dark      = r_dark;
    assign o_is_light     = r_light;
    assign o_window_full  = r_full;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Light level moving average testbench
// Drives paced light samples through the valid/ready request channel and
// checks every result against a scoreboard that predicts the mean, the
// extremes, the dark and light flags and the window fill flag.
// The run moves through several threshold settings and idle patterns.
// ----------------------------------------------------------------------------
module tb
    import lma_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int SEGMENTS       = 8;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LEVEL_MAX      = (1 << LMA_SAMPLE_BITS) - 1;

    typedef logic [LMA_SAMPLE_BITS-1:0] level_t;

    typedef struct packed {
        level_t mean_level;
        level_t lowest_mean;
        level_t highest_mean;
        logic   is_dark;
        logic   is_light;
        logic   window_full;
    } light_result_t;

    class light_mean_scoreboard;
        level_t        ring [LMA_WINDOW];
        int            write_pos;
        bit            filled;
        int            total;
        level_t        lowest;
        level_t        highest;
        level_t        threshold;
        light_result_t pending_means [$];
        int            n_errors;
        int            n_checked;
        int            n_dark;
        int            n_light;
        int            n_equal;

        function new();
            foreach (ring[i]) ring[i] = '0;
            write_pos = 0;
            filled    = 0;
            total     = 0;
            lowest    = level_t'(LEVEL_MAX);
            highest   = '0;
            threshold = level_t'(LMA_THRESHOLD_RESET);
            n_errors  = 0;
            n_checked = 0;
            n_dark    = 0;
            n_light   = 0;
            n_equal   = 0;
        endfunction

        function void set_threshold(level_t value);
            threshold = value;
        endfunction

        function int pending();
            return pending_means.size();
        endfunction

        function void note_sample(level_t sample);
            light_result_t r;
            int            count;
            level_t        mean;
            if (filled) total -= ring[write_pos];
            total += sample;
            ring[write_pos] = sample;
            write_pos = (write_pos == LMA_WINDOW - 1) ? 0 : write_pos + 1;
            if (write_pos == 0) filled = 1;
            count = filled ? LMA_WINDOW : write_pos;
            mean  = level_t'(total / count);
            if (mean < lowest) lowest = mean;
            if (mean > highest) highest = mean;
            r.mean_level   = mean;
            r.lowest_mean  = lowest;
            r.highest_mean = highest;
            r.is_dark      = (mean < threshold);
            r.is_light     = (mean > threshold);
            r.window_full  = filled;
            pending_means.push_back(r);
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual) begin
                $error("%s: expected %0d, actual %0d", name, expected, actual);
                n_errors++;
            end
        endfunction

        function void check_result(light_result_t got);
            light_result_t want;
            if (pending_means.size() == 0) begin
                $error("result with no request outstanding: mean_level %0d",
                       got.mean_level);
                n_errors++;
                return;
            end
            want = pending_means.pop_front();
            n_checked++;
            if (want.is_dark) n_dark++;
            else if (want.is_light) n_light++;
            else n_equal++;
            compare_field("mean_level", want.mean_level, got.mean_level);
            compare_field("lowest_mean", want.lowest_mean, got.lowest_mean);
            compare_field("highest_mean", want.highest_mean, got.highest_mean);
            compare_field("is_dark", want.is_dark, got.is_dark);
            compare_field("is_light", want.is_light, got.is_light);
            compare_field("window_full", want.window_full, got.window_full);
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    level_t i_cfg_wdata;
    logic   i_valid;
    logic   o_ready;
    level_t i_sample;
    logic   o_valid;
    logic   i_ready;
    level_t o_mean_level;
    level_t o_lowest_mean;
    level_t o_highest_mean;
    logic   o_is_dark;
    logic   o_is_light;
    logic   o_window_full;

    light_mean_scoreboard sb = new();

    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    int     samples_sent  = 0;
    int     threshold_writes = 0;
    int     quiet_cycles  = 0;
    level_t last_sample   = '0;

    light_level_moving_average uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mean_level   (o_mean_level),
        .o_lowest_mean  (o_lowest_mean),
        .o_highest_mean (o_highest_mean),
        .o_is_dark      (o_is_dark),
        .o_is_light     (o_is_light),
        .o_window_full  (o_window_full)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        light_result_t seen;
        if (i_rst_n && o_valid && i_ready) begin
            seen.mean_level   = o_mean_level;
            seen.lowest_mean  = o_lowest_mean;
            seen.highest_mean = o_highest_mean;
            seen.is_dark      = o_is_dark;
            seen.is_light     = o_is_light;
            seen.window_full  = o_window_full;
            sb.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("light_level_moving_average verification failed");
            $finish;
        end
    end

    task automatic send_sample(level_t sample);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_sample = sample;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(sample);
        samples_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(level_t value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        sb.set_threshold(value);
        threshold_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic level_t pick_sample(level_t thr);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            v = $urandom_range(0, LEVEL_MAX);
        end else if (roll < 55) begin
            v = $urandom_range(0, 1) ? LEVEL_MAX : 0;
        end else if (roll < 80) begin
            v = int'(thr) + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            if (v > LEVEL_MAX) v = LEVEL_MAX;
        end else begin
            v = last_sample;
        end
        last_sample = level_t'(v);
        return level_t'(v);
    endfunction

    initial begin
        int     seg;
        int     n;
        int     per_seg;
        level_t thr;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_sample    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Partial window fill, overwrite of the oldest entry, mean equal to
        // the default threshold, then both threshold extremes.
        send_sample('0);
        repeat (8) send_sample(level_t'(LEVEL_MAX));
        repeat (8) send_sample(level_t'(LMA_THRESHOLD_RESET));
        write_threshold('0);
        repeat (4) send_sample('0);
        write_threshold(level_t'(LEVEL_MAX));
        repeat (4) send_sample(level_t'(LEVEL_MAX));

        per_seg = RANDOM_ITEMS / SEGMENTS;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: thr = '0;
                1: thr = level_t'(LEVEL_MAX);
                default: thr = level_t'($urandom_range(0, LEVEL_MAX));
            endcase
            write_threshold(thr);
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            for (n = 0; n < per_seg; n++) begin
                if ($urandom_range(0, 99) == 0) wait_drained();
                send_sample(pick_sample(thr));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples under %0d threshold writes and four idle patterns.",
                 samples_sent, threshold_writes);
        $display("Checked %0d results: %0d dark, %0d light, %0d at threshold; %0d errors.",
                 sb.n_checked, sb.n_dark, sb.n_light, sb.n_equal, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("light_level_moving_average verification clean");
        end else begin
            $display("light_level_moving_average verification failed");
        end
        $finish;
    end

endmodule
